/* design/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg: shared types and constants of the pitch to phase increment block
// Holds the stage advance struct, the octave split constants and the two
// exponential tables (coarse step per 64 cents-of-2400, fine step per unit).
// ----------------------------------------------------------------------------
package ppi_pkg;

  typedef struct packed {
    logic in_load;
    logic split;
    logic lookup;
    logic scale;
    logic out;
  } ppi_adv_t;

  localparam logic [16:0] PitchOffset = 17'd34103;
  localparam logic [16:0] StepsPerOct = 17'd2400;
  localparam logic [33:0] RecipMul    = 34'd111849;
  localparam int          RecipShift  = 28;
  localparam logic [5:0]  ShiftBase   = 6'd27;
  localparam logic [4:0]  MaxOctave   = 5'd27;
  localparam logic [11:0] RemLimit    = 12'd2400;

  function automatic logic [15:0] coarse_entry(input logic [5:0] idx);
    logic [15:0] val;
    case (idx)
      6'd0:  val = 16'd14417;  6'd1:  val = 16'd14686;
      6'd2:  val = 16'd14960;  6'd3:  val = 16'd15240;
      6'd4:  val = 16'd15524;  6'd5:  val = 16'd15813;
      6'd6:  val = 16'd16108;  6'd7:  val = 16'd16409;
      6'd8:  val = 16'd16715;  6'd9:  val = 16'd17027;
      6'd10: val = 16'd17345;  6'd11: val = 16'd17668;
      6'd12: val = 16'd17998;  6'd13: val = 16'd18334;
      6'd14: val = 16'd18676;  6'd15: val = 16'd19024;
      6'd16: val = 16'd19379;  6'd17: val = 16'd19741;
      6'd18: val = 16'd20109;  6'd19: val = 16'd20484;
      6'd20: val = 16'd20866;  6'd21: val = 16'd21255;
      6'd22: val = 16'd21652;  6'd23: val = 16'd22056;
      6'd24: val = 16'd22467;  6'd25: val = 16'd22887;
      6'd26: val = 16'd23313;  6'd27: val = 16'd23748;
      6'd28: val = 16'd24191;  6'd29: val = 16'd24643;
      6'd30: val = 16'd25103;  6'd31: val = 16'd25571;
      6'd32: val = 16'd26048;  6'd33: val = 16'd26534;
      6'd34: val = 16'd27029;  6'd35: val = 16'd27533;
      6'd36: val = 16'd28047;  6'd37: val = 16'd28570;
      6'd38: val = 16'd29103;  6'd39: val = 16'd29646;
      6'd40: val = 16'd30199;  6'd41: val = 16'd30763;
      6'd42: val = 16'd31336;  6'd43: val = 16'd31921;
      6'd44: val = 16'd32517;  6'd45: val = 16'd33123;
      6'd46: val = 16'd33741;  6'd47: val = 16'd34371;
      6'd48: val = 16'd35012;  6'd49: val = 16'd35665;
      6'd50: val = 16'd36330;  6'd51: val = 16'd37008;
      6'd52: val = 16'd37699;  6'd53: val = 16'd38402;
      6'd54: val = 16'd39118;  6'd55: val = 16'd39848;
      6'd56: val = 16'd40592;  6'd57: val = 16'd41349;
      6'd58: val = 16'd42120;  6'd59: val = 16'd42906;
      6'd60: val = 16'd43706;  6'd61: val = 16'd44522;
      6'd62: val = 16'd45352;  6'd63: val = 16'd46199;
      default: val = 16'd14417;
    endcase
    return val;
  endfunction

  function automatic logic [15:0] fine_entry(input logic [5:0] idx);
    logic [15:0] val;
    case (idx)
      6'd0:  val = 16'd48059;  6'd1:  val = 16'd48073;
      6'd2:  val = 16'd48087;  6'd3:  val = 16'd48101;
      6'd4:  val = 16'd48115;  6'd5:  val = 16'd48129;
      6'd6:  val = 16'd48143;  6'd7:  val = 16'd48156;
      6'd8:  val = 16'd48170;  6'd9:  val = 16'd48184;
      6'd10: val = 16'd48198;  6'd11: val = 16'd48212;
      6'd12: val = 16'd48226;  6'd13: val = 16'd48240;
      6'd14: val = 16'd48254;  6'd15: val = 16'd48268;
      6'd16: val = 16'd48282;  6'd17: val = 16'd48296;
      6'd18: val = 16'd48310;  6'd19: val = 16'd48324;
      6'd20: val = 16'd48338;  6'd21: val = 16'd48352;
      6'd22: val = 16'd48366;  6'd23: val = 16'd48380;
      6'd24: val = 16'd48394;  6'd25: val = 16'd48407;
      6'd26: val = 16'd48421;  6'd27: val = 16'd48435;
      6'd28: val = 16'd48449;  6'd29: val = 16'd48463;
      6'd30: val = 16'd48477;  6'd31: val = 16'd48491;
      6'd32: val = 16'd48505;  6'd33: val = 16'd48519;
      6'd34: val = 16'd48533;  6'd35: val = 16'd48548;
      6'd36: val = 16'd48562;  6'd37: val = 16'd48576;
      6'd38: val = 16'd48590;  6'd39: val = 16'd48604;
      6'd40: val = 16'd48618;  6'd41: val = 16'd48632;
      6'd42: val = 16'd48646;  6'd43: val = 16'd48660;
      6'd44: val = 16'd48674;  6'd45: val = 16'd48688;
      6'd46: val = 16'd48702;  6'd47: val = 16'd48716;
      6'd48: val = 16'd48730;  6'd49: val = 16'd48744;
      6'd50: val = 16'd48758;  6'd51: val = 16'd48772;
      6'd52: val = 16'd48786;  6'd53: val = 16'd48801;
      6'd54: val = 16'd48815;  6'd55: val = 16'd48829;
      6'd56: val = 16'd48843;  6'd57: val = 16'd48857;
      6'd58: val = 16'd48871;  6'd59: val = 16'd48885;
      6'd60: val = 16'd48899;  6'd61: val = 16'd48913;
      6'd62: val = 16'd48928;  6'd63: val = 16'd48942;
      default: val = 16'd48059;
    endcase
    return val;
  endfunction

endpackage

/* design/ppi_split.sv */
// ----------------------------------------------------------------------------
// ppi_split: pitch offset and octave extraction
// Offsets the signed pitch to a positive step count and divides it by the
// steps per octave through a reciprocal multiply.
// ----------------------------------------------------------------------------
module ppi_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppi_pkg::ppi_adv_t   adv_i,
  input  logic signed [15:0]  pitch_i,
  input  logic        [3:0]   upow_i,
  output logic        [16:0]  pos_o,
  output logic        [4:0]   oct_o,
  output logic        [3:0]   upow_o
);

  logic [16:0] pos_d, pos_q;
  logic [33:0] recip;
  logic [4:0]  oct_d, oct_q;
  logic [3:0]  upow_q;

  always_comb begin
    pos_d = {pitch_i[15], pitch_i} + ppi_pkg::PitchOffset;
    recip = {17'd0, pos_d} * ppi_pkg::RecipMul;
    oct_d = recip[ppi_pkg::RecipShift+4:ppi_pkg::RecipShift];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.split) begin
      pos_q  <= pos_d;
      oct_q  <= oct_d;
      upow_q <= upow_i;
    end
  end

  assign pos_o  = pos_q;
  assign oct_o  = oct_q;
  assign upow_o = upow_q;

  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.split |-> oct_d <= ppi_pkg::MaxOctave)
    else $error("octave out of range");

endmodule

/* design/ppi_lookup.sv */
// ----------------------------------------------------------------------------
// ppi_lookup: remainder split, table lookup and shift count
// Forms the in-octave remainder, reads the coarse and fine tables and works
// out the right shift that places the product in the right octave.
// ----------------------------------------------------------------------------
module ppi_lookup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppi_pkg::ppi_adv_t  adv_i,
  input  logic [16:0]        pos_i,
  input  logic [4:0]         oct_i,
  input  logic [3:0]         upow_i,
  output logic [15:0]        coarse_o,
  output logic [15:0]        fine_o,
  output logic [4:0]         shamt_o
);

  logic [16:0] rem_full;
  logic [11:0] rem;
  logic [5:0]  oct_sum;
  logic [15:0] coarse_d, coarse_q;
  logic [15:0] fine_d, fine_q;
  logic [4:0]  shamt_d, shamt_q;

  always_comb begin
    rem_full = pos_i - ({12'd0, oct_i} * ppi_pkg::StepsPerOct);
    rem      = rem_full[11:0];
    coarse_d = ppi_pkg::coarse_entry(rem[11:6]);
    fine_d   = ppi_pkg::fine_entry(rem[5:0]);
    oct_sum  = {1'b0, oct_i} + {2'd0, upow_i};
    if (oct_sum < ppi_pkg::ShiftBase) begin
      shamt_d = 5'(ppi_pkg::ShiftBase - oct_sum);
    end else begin
      shamt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.lookup) begin
      coarse_q <= coarse_d;
      fine_q   <= fine_d;
      shamt_q  <= shamt_d;
    end
  end

  assign coarse_o = coarse_q;
  assign fine_o   = fine_q;
  assign shamt_o  = shamt_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.lookup |-> rem_full < {5'd0, ppi_pkg::RemLimit})
    else $error("remainder not below one octave");

  a_shamt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.lookup |-> shamt_d <= ppi_pkg::ShiftBase[4:0])
    else $error("shift count out of range");

endmodule

/* design/ppi_scale.sv */
// ----------------------------------------------------------------------------
// ppi_scale: table product
// Multiplies the coarse and fine entries, doubles the product and carries
// the shift count alongside.
// ----------------------------------------------------------------------------
module ppi_scale (
  input  logic               clk_i,
  input  ppi_pkg::ppi_adv_t  adv_i,
  input  logic [15:0]        coarse_i,
  input  logic [15:0]        fine_i,
  input  logic [4:0]         shamt_i,
  output logic [31:0]        prod_o,
  output logic [4:0]         shamt_o
);

  logic [31:0] mul;
  logic [31:0] prod_d, prod_q;
  logic [4:0]  shamt_q;

  always_comb begin
    mul    = coarse_i * fine_i;
    prod_d = {mul[30:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.scale) begin
      prod_q  <= prod_d;
      shamt_q <= shamt_i;
    end
  end

  assign prod_o  = prod_q;
  assign shamt_o = shamt_q;

endmodule

/* design/pitch_to_phase_increment.sv */
// ----------------------------------------------------------------------------
// pitch_to_phase_increment: exponential pitch to phase increment converter
// Five-stage pipeline: input register, octave split, table lookup, product,
// shift and output register.
// ----------------------------------------------------------------------------
// Takes one word per cycle while stall_o is low; each phase increment leaves
// through the output register. Each stage holds its word until the next stage
// is free, so a stalled output lets the stages behind it fill up before stall_o
// rises; throughput is one word per cycle unless the output stalls, since each
// of the five registered stages (input, reciprocal multiply, tables, 16x16
// product, shift) advances whenever the stage ahead of it is free or moving.
module pitch_to_phase_increment (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] pitch_i,
  input  logic        [3:0]  undersample_power_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic        [31:0] phase_increment_o
);

  ppi_pkg::ppi_adv_t adv;

  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3, rdyo;

  logic signed [15:0] pitch_q;
  logic [3:0]         upow_q;
  logic [16:0]        pos;
  logic [4:0]         oct;
  logic [3:0]         upow1;
  logic [15:0]        coarse, fine;
  logic [4:0]         shamt2, shamt3;
  logic [31:0]        prod;
  logic [31:0]        result_d, result_q;

  always_comb begin
    rdyo = !vo_q || !stall_i;
    rdy3 = !v3_q || rdyo;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    rdy0 = !v0_q || rdy1;
    adv.in_load = valid_i && rdy0;
    adv.split   = v0_q && rdy1;
    adv.lookup  = v1_q && rdy2;
    adv.scale   = v2_q && rdy3;
    adv.out     = v3_q && rdyo;
  end

  assign stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.in_load) begin
      pitch_q <= pitch_i;
      upow_q  <= undersample_power_i;
    end
  end

  ppi_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .pitch_i (pitch_q),
    .upow_i  (upow_q),
    .pos_o   (pos),
    .oct_o   (oct),
    .upow_o  (upow1)
  );

  ppi_lookup u_lookup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .pos_i    (pos),
    .oct_i    (oct),
    .upow_i   (upow1),
    .coarse_o (coarse),
    .fine_o   (fine),
    .shamt_o  (shamt2)
  );

  ppi_scale u_scale (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .coarse_i (coarse),
    .fine_i   (fine),
    .shamt_i  (shamt2),
    .prod_o   (prod),
    .shamt_o  (shamt3)
  );

  assign result_d = prod >> shamt3;

  always_ff @(posedge clk_i) begin
    if (adv.out) begin
      result_q <= result_d;
    end
  end

  assign valid_o           = vo_q;
  assign phase_increment_o = result_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v0_q && v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled with a free stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !stall_i && !v3_q) |=> !valid_o)
    else $error("output word repeated");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !vo_q) |=> valid_o)
    else $error("word lost before output");

endmodule

/* bench/pitch_to_phase_increment_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_to_phase_increment_tb: self-checking bench for the pitch converter
// Sends directed corner pitches and random pitch/undersample words under
// random idling on both sides. It also stalls the output for a long stretch
// once, so that the pipeline fills up. Each phase increment is checked
// against a local prediction built from the exponential tables.
// ----------------------------------------------------------------------------
module pitch_to_phase_increment_tb;

  localparam int PitchBias      = 28 * 2400 - 32767 - 330;
  localparam int StepsPerOctave = 2400;
  localparam int StepsPerIndex  = 64;
  localparam int ShiftTop       = 27;
  localparam int IdlePercent    = 16;
  localparam int RandomWords    = 600;
  localparam int HoldoffStart   = 120;
  localparam int HoldoffCycles  = 80;
  localparam int QuietFirst     = 350;
  localparam int QuietLast      = 470;
  localparam int DrainCycles    = 20;

  localparam logic [0:63][15:0] CoarseStep = {
    16'd14417, 16'd14686, 16'd14960, 16'd15240, 16'd15524, 16'd15813, 16'd16108, 16'd16409,
    16'd16715, 16'd17027, 16'd17345, 16'd17668, 16'd17998, 16'd18334, 16'd18676, 16'd19024,
    16'd19379, 16'd19741, 16'd20109, 16'd20484, 16'd20866, 16'd21255, 16'd21652, 16'd22056,
    16'd22467, 16'd22887, 16'd23313, 16'd23748, 16'd24191, 16'd24643, 16'd25103, 16'd25571,
    16'd26048, 16'd26534, 16'd27029, 16'd27533, 16'd28047, 16'd28570, 16'd29103, 16'd29646,
    16'd30199, 16'd30763, 16'd31336, 16'd31921, 16'd32517, 16'd33123, 16'd33741, 16'd34371,
    16'd35012, 16'd35665, 16'd36330, 16'd37008, 16'd37699, 16'd38402, 16'd39118, 16'd39848,
    16'd40592, 16'd41349, 16'd42120, 16'd42906, 16'd43706, 16'd44522, 16'd45352, 16'd46199
  };

  localparam logic [0:63][15:0] FineStep = {
    16'd48059, 16'd48073, 16'd48087, 16'd48101, 16'd48115, 16'd48129, 16'd48143, 16'd48156,
    16'd48170, 16'd48184, 16'd48198, 16'd48212, 16'd48226, 16'd48240, 16'd48254, 16'd48268,
    16'd48282, 16'd48296, 16'd48310, 16'd48324, 16'd48338, 16'd48352, 16'd48366, 16'd48380,
    16'd48394, 16'd48407, 16'd48421, 16'd48435, 16'd48449, 16'd48463, 16'd48477, 16'd48491,
    16'd48505, 16'd48519, 16'd48533, 16'd48548, 16'd48562, 16'd48576, 16'd48590, 16'd48604,
    16'd48618, 16'd48632, 16'd48646, 16'd48660, 16'd48674, 16'd48688, 16'd48702, 16'd48716,
    16'd48730, 16'd48744, 16'd48758, 16'd48772, 16'd48786, 16'd48801, 16'd48815, 16'd48829,
    16'd48843, 16'd48857, 16'd48871, 16'd48885, 16'd48899, 16'd48913, 16'd48928, 16'd48942
  };

  typedef struct packed {
    logic signed [15:0] pitch;
    logic        [3:0]  upow;
  } pitch_word_t;

  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               valid_i             = 1'b0;
  logic               stall_o;
  logic signed [15:0] pitch_i             = '0;
  logic        [3:0]  undersample_power_i = '0;
  logic               valid_o;
  logic               stall_i             = 1'b0;
  logic        [31:0] phase_increment_o;

  pitch_word_t pending_words[$];
  logic [31:0] expected_increments[$];
  pitch_word_t next_word;
  logic [31:0] want;
  int          words_accepted = 0;
  int          results_seen   = 0;
  int          mismatch_count = 0;
  int          holdoff_left   = 0;
  bit          holdoff_done   = 1'b0;
  bit          send_quiet;
  bit          recv_quiet;

  pitch_to_phase_increment u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (valid_i),
    .stall_o             (stall_o),
    .pitch_i             (pitch_i),
    .undersample_power_i (undersample_power_i),
    .valid_o             (valid_o),
    .stall_i             (stall_i),
    .phase_increment_o   (phase_increment_o)
  );

  function automatic logic [31:0] phase_increment_of(input logic signed [15:0] pitch,
                                                     input logic [3:0] upow);
    int          wide_pitch;
    int          offset_pitch;
    int          octave;
    int          remainder;
    int          shift;
    logic [63:0] product;
    wide_pitch   = pitch;
    offset_pitch = wide_pitch + PitchBias;
    octave       = offset_pitch / StepsPerOctave;
    remainder    = offset_pitch % StepsPerOctave;
    product      = 64'd2 * 64'(CoarseStep[(remainder / StepsPerIndex) % 64])
                         * 64'(FineStep[remainder % StepsPerIndex]);
    shift        = ShiftTop - octave - int'(upow);
    if (shift > 0) begin
      product = product >> shift;
    end
    return product[31:0];
  endfunction

  task automatic queue_word(input int pitch, input int upow);
    pitch_word_t w;
    w.pitch = 16'(pitch);
    w.upow  = 4'(upow);
    pending_words.push_back(w);
  endtask

  assign send_quiet = (words_accepted >= QuietFirst) && (words_accepted < QuietLast);
  assign recv_quiet = (results_seen >= QuietFirst) && (results_seen < QuietLast);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // sender: record the accepted word, then offer the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        expected_increments.push_back(phase_increment_of(pitch_i, undersample_power_i));
        words_accepted <= words_accepted + 1;
      end
      if (!valid_i || !stall_o) begin
        if (pending_words.size() != 0 &&
            (send_quiet || $urandom_range(99) >= IdlePercent)) begin
          next_word            = pending_words.pop_front();
          valid_i             <= 1'b1;
          pitch_i             <= next_word.pitch;
          undersample_power_i <= next_word.upow;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // hold the output off once, long enough to back the pipeline up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && words_accepted >= HoldoffStart) begin
        holdoff_left <= HoldoffCycles;
        holdoff_done <= 1'b1;
      end
    end
  end

  // receiver: check each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (expected_increments.size() == 0) begin
          $display("%0t: phase_increment expected none actual %0d", $time, phase_increment_o);
          mismatch_count++;
        end else begin
          want = expected_increments.pop_front();
          if (phase_increment_o !== want) begin
            $display("%0t: phase_increment expected %0d actual %0d",
                     $time, want, phase_increment_o);
            mismatch_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      stall_i <= (holdoff_left != 0) ||
                 (!recv_quiet && $urandom_range(99) < IdlePercent);
    end
  end

  initial begin
    queue_word(-32768, 0);
    queue_word(-32768, 15);
    queue_word(32767, 0);
    queue_word(32767, 15);
    queue_word(0, 0);
    queue_word(-1, 7);
    queue_word(1, 3);
    queue_word(30697, 0);
    queue_word(30696, 0);
    queue_word(30696, 1);
    queue_word(-440, 5);
    queue_word(-503, 13);
    queue_word(-503, 12);
    queue_word(-31704, 0);
    queue_word(-21846, 10);
    queue_word(21845, 5);
    for (int i = 0; i < RandomWords; i++) begin
      queue_word(int'($urandom_range(65535)), int'($urandom_range(15)));
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || valid_i || expected_increments.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
design/ppi_pkg.sv
design/ppi_split.sv
design/ppi_lookup.sv
design/ppi_scale.sv
design/pitch_to_phase_increment.sv
bench/pitch_to_phase_increment_tb.sv
